### rtl/pcs_pkg.sv
// shared types and constants for the program counter sequencer
package pcs_pkg;

   // field widths
   localparam int ADDR_BITS  = 16;
   localparam int COND_BITS  = 3;
   localparam int FLAG_BITS  = 7;
   localparam int RET_BITS   = 2;
   localparam int IRQ_LINES  = 3;
   localparam int SRC_BITS   = 3;
   localparam int CSR_IDX_BITS = 8;

   // packed request fields, lowest bits last in the declaration
   localparam int REQ_BITS   = 49;
   localparam int REQ_TDATA_BITS = 56;
   localparam int RSP_TDATA_BITS = 24;

   // pc source codes
   localparam logic [SRC_BITS-1:0] SRC_INCREMENT = 3'd0;
   localparam logic [SRC_BITS-1:0] SRC_INT0      = 3'd1;
   localparam logic [SRC_BITS-1:0] SRC_INT1      = 3'd2;
   localparam logic [SRC_BITS-1:0] SRC_INT2      = 3'd3;
   localparam logic [SRC_BITS-1:0] SRC_RETURN    = 3'd4;
   localparam logic [SRC_BITS-1:0] SRC_HOLD      = 3'd5;
   localparam logic [SRC_BITS-1:0] SRC_LOAD      = 3'd6;
   localparam logic [SRC_BITS-1:0] SRC_JUMP      = 3'd7;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_VECTOR_ZERO      = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VECTOR_ONE       = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VECTOR_TWO       = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERRUPT_ENABLE = 8'd3;

   // jump condition meaning no jump
   localparam logic [COND_BITS-1:0] COND_NONE = 3'd0;

   typedef struct packed {
      logic [IRQ_LINES-1:0] interrupt_requests;
      logic                 timer_hold;
      logic [RET_BITS-1:0]  return_control;
      logic [FLAG_BITS-1:0] condition_flags;
      logic [ADDR_BITS-1:0] jump_offset;
      logic [COND_BITS-1:0] jump_condition;
      logic [ADDR_BITS-1:0] load_value;
      logic                 load_valid;
   } req_type;

endpackage

### rtl/program_counter_sequencer_core.sv
// program counter sequencer: picks the next fetch address once per instruction cycle
// path: a response follows its request transfer through the input register, then the
//   result register, one response per request
// throughput: one request per cycle unless the response stalls; next-pc is combinational
// reset: synchronous, active high; clears pc, return address, in-service, pending
//   requests, interrupt vectors and enables, and both pipeline valid flags
module program_counter_sequencer_core #(
   parameter int PC_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // fields from bit 0: load_valid, load_value[15:0], jump_condition[2:0],
   // jump_offset[15:0], condition_flags[6:0], return_control[1:0],
   // timer_hold, interrupt_requests[2:0], zero fill
   input  logic [pcs_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // fields from bit 0: program_counter[15:0], in_service, zero fill
   output logic [pcs_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // fields from bit 0: pc_source[2:0]
   output logic [pcs_pkg::SRC_BITS-1:0]         rsp_tuser,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pcs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [pcs_pkg::ADDR_BITS-1:0]        csr_data
);

   // ---------------------------------------------------------------- handshakes
   logic req_xfer;
   logic advance;      // result register can take a new value
   logic step;         // the held request is evaluated this cycle

   logic             s1_valid_ff, s1_valid_in;
   pcs_pkg::req_type s1_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // input register, payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         s1_data_ff <= pcs_pkg::req_type'(req_tdata[pcs_pkg::REQ_BITS-1:0]);
      end
   end

   // ---------------------------------------------------------------- registers
   logic [pcs_pkg::ADDR_BITS-1:0] vector_zero_ff, vector_one_ff, vector_two_ff;
   logic [pcs_pkg::IRQ_LINES-1:0] irq_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_zero_ff <= '0;
         vector_one_ff  <= '0;
         vector_two_ff  <= '0;
         irq_enable_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pcs_pkg::CSR_VECTOR_ZERO:      vector_zero_ff <= csr_data;
            pcs_pkg::CSR_VECTOR_ONE:       vector_one_ff  <= csr_data;
            pcs_pkg::CSR_VECTOR_TWO:       vector_two_ff  <= csr_data;
            pcs_pkg::CSR_INTERRUPT_ENABLE: irq_enable_ff  <= csr_data[pcs_pkg::IRQ_LINES-1:0];
            default: ;   // writes past the list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer state
   logic [PC_WIDTH-1:0]           pc_ff, pc_in;
   logic [PC_WIDTH-1:0]           ret_addr_ff, ret_addr_in;
   logic                          svc_ff, svc_in;
   logic [pcs_pkg::IRQ_LINES-1:0] pend_irq_ff, pend_irq_in;
   logic                          pend_load_ff, pend_load_in;
   logic [PC_WIDTH-1:0]           load_tgt_ff, load_tgt_in;
   logic                          pend_jump_ff, pend_jump_in;
   logic [PC_WIDTH-1:0]           jump_tgt_ff, jump_tgt_in;
   logic [pcs_pkg::SRC_BITS-1:0]  src;

   // intermediate values once the cycle's requests are recorded
   logic                          cond_hit;
   logic [pcs_pkg::FLAG_BITS:0]   cond_vec;
   logic [PC_WIDTH-1:0]           offset;
   logic [PC_WIDTH-1:0]           pc_plus_one;
   logic                          load_rec;
   logic [PC_WIDTH-1:0]           load_tgt_rec;
   logic                          jump_rec;
   logic [PC_WIDTH-1:0]           jump_tgt_rec;
   logic                          ret_req;     // return request lives for this cycle only
   logic                          svc_rec;
   logic [pcs_pkg::IRQ_LINES-1:0] irq_rec;
   logic                          take_int;

   always_comb begin
      pc_plus_one = pc_ff + PC_WIDTH'(1);
      offset      = PC_WIDTH'(s1_data_ff.jump_offset);

      // load request, a newer load replaces the target
      load_rec     = pend_load_ff || s1_data_ff.load_valid;
      load_tgt_rec = s1_data_ff.load_valid ? PC_WIDTH'(s1_data_ff.load_value) : load_tgt_ff;

      // condition c tests flag bit c-1; bit 0 of cond_vec stands for no condition
      cond_vec = {s1_data_ff.condition_flags, 1'b0};
      cond_hit = (s1_data_ff.jump_condition != pcs_pkg::COND_NONE) &&
                 cond_vec[s1_data_ff.jump_condition];
      jump_rec = pend_jump_ff || cond_hit;
      if (cond_hit) begin
         jump_tgt_rec = s1_data_ff.jump_offset[0] ? (pc_ff + offset) : (pc_ff - offset);
      end else begin
         jump_tgt_rec = jump_tgt_ff;
      end

      // return bits, then interrupt latch gated by in-service
      ret_req = s1_data_ff.return_control[0];
      svc_rec = s1_data_ff.return_control[1] ? 1'b0 : svc_ff;
      irq_rec = svc_rec ? pend_irq_ff
                        : (pend_irq_ff | (s1_data_ff.interrupt_requests & irq_enable_ff));
      take_int = |irq_rec;

      // defaults: keep what was recorded
      ret_addr_in  = ret_addr_ff;
      svc_in       = svc_rec;
      pend_irq_in  = irq_rec;
      pend_load_in = load_rec;
      load_tgt_in  = load_tgt_rec;
      pend_jump_in = jump_rec;
      jump_tgt_in  = jump_tgt_rec;

      // fixed priority next-pc selection
      if (take_int) begin
         if (irq_rec[0]) begin
            pc_in = PC_WIDTH'(vector_zero_ff);
            src   = pcs_pkg::SRC_INT0;
         end else if (irq_rec[1]) begin
            pc_in = PC_WIDTH'(vector_one_ff);
            src   = pcs_pkg::SRC_INT1;
         end else begin
            pc_in = PC_WIDTH'(vector_two_ff);
            src   = pcs_pkg::SRC_INT2;
         end
         pend_irq_in = '0;
         ret_addr_in = pc_plus_one;
         svc_in      = 1'b1;
      end else if (ret_req) begin
         pc_in = ret_addr_ff;
         src   = pcs_pkg::SRC_RETURN;
      end else if (s1_data_ff.timer_hold) begin
         pc_in = pc_ff;
         src   = pcs_pkg::SRC_HOLD;
      end else if (load_rec) begin
         pc_in        = load_tgt_rec;
         src          = pcs_pkg::SRC_LOAD;
         pend_load_in = 1'b0;
      end else if (jump_rec) begin
         pc_in        = jump_tgt_rec;
         src          = pcs_pkg::SRC_JUMP;
         pend_jump_in = 1'b0;
      end else begin
         pc_in = pc_plus_one;
         src   = pcs_pkg::SRC_INCREMENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         ret_addr_ff  <= '0;
         svc_ff       <= 1'b0;
         pend_irq_ff  <= '0;
         pend_load_ff <= 1'b0;
         load_tgt_ff  <= '0;
         pend_jump_ff <= 1'b0;
         jump_tgt_ff  <= '0;
      end else if (step) begin
         pc_ff        <= pc_in;
         ret_addr_ff  <= ret_addr_in;
         svc_ff       <= svc_in;
         pend_irq_ff  <= pend_irq_in;
         pend_load_ff <= pend_load_in;
         load_tgt_ff  <= load_tgt_in;
         pend_jump_ff <= pend_jump_in;
         jump_tgt_ff  <= jump_tgt_in;
      end
   end

   // ---------------------------------------------------------------- result register
   logic [pcs_pkg::ADDR_BITS-1:0] rsp_pc_ff;
   logic                          rsp_svc_ff;
   logic [pcs_pkg::SRC_BITS-1:0]  rsp_src_ff;

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_pc_ff  <= pcs_pkg::ADDR_BITS'(pc_in);
         rsp_svc_ff <= svc_in;
         rsp_src_ff <= src;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pcs_pkg::RSP_TDATA_BITS - pcs_pkg::ADDR_BITS - 1){1'b0}},
                        rsp_svc_ff, rsp_pc_ff};
   assign rsp_tuser  = rsp_src_ff;

   // ---------------------------------------------------------------- checks
   // an interrupt response always reports in-service
   a_int_sets_service: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pcs_pkg::SRC_INT0 || rsp_tuser == pcs_pkg::SRC_INT1 ||
                     rsp_tuser == pcs_pkg::SRC_INT2) |-> rsp_tdata[pcs_pkg::ADDR_BITS])
      else $error("interrupt response without in-service");

   // taking an interrupt drops every pending line
   a_int_clears_pending: assert property (@(posedge clock) disable iff (reset)
      step && take_int |=> pend_irq_ff == '0)
      else $error("pending interrupts survive an interrupt");

   // requests stall only while both stages are full
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with free stage");

endmodule
